// ----- rtl/grid_segregation_relocate_step_unit_macros.svh -----
// Assertion macros for the grid relocate step unit.
`ifndef GRID_SEGREGATION_RELOCATE_STEP_UNIT_MACROS_SVH
`define GRID_SEGREGATION_RELOCATE_STEP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define GSR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define GSR_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSR_ASSERT(name, prop, msg)
`define GSR_ASSERT_NR(name, prop, msg)
`endif

`endif

// ----- rtl/gsr_pkg.sv -----
// Package: grid constants, opcodes, controller command and status types.
`default_nettype none
package gsr_pkg;

  localparam int GRID_SIDE = 64;
  localparam int CW        = 6;
  localparam int AW        = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int NB_SIDE   = 3;
  localparam int NB_N      = NB_SIDE * NB_SIDE;
  localparam int NB_IW     = $clog2(NB_N);
  localparam int NB_CW     = $clog2(NB_SIDE);
  localparam int CENTRE_IDX = NB_N / 2;
  localparam int CNT_W     = 4;
  localparam int THR_W     = 5;

  localparam logic signed [THR_W-1:0] THR_MIN   = -5'sd1;
  localparam logic signed [THR_W-1:0] THR_MAX   = 5'sd8;
  localparam logic signed [THR_W-1:0] THR_RESET = 5'sd3;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_RELOCATE = 2'd2;

  typedef enum logic [1:0] {ADDR_HERE, ADDR_NB, ADDR_THERE} addr_sel_t;
  typedef enum logic [1:0] {WD_VALUE, WD_TVAL, WD_CENTRE} wd_sel_t;
  typedef enum logic [1:0] {CELL_KEEP, CELL_VALUE, CELL_RDATA, CELL_CENTRE} cell_sel_t;

  typedef struct packed {
    logic      load_item;
    addr_sel_t addr_sel;
    logic      mem_we;
    wd_sel_t   wd_sel;
    logic      nb_clr;
    logic      nb_adv;
    logic      eval;
    logic      tgt_cap;
    cell_sel_t cell_sel;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       in_grid;
    logic       interior;
    logic       nb_last;
    logic       moves;
    logic       out_free;
  } sts_t;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                               input logic [CW-1:0] c);
    cell_addr = AW'(r) * AW'(GRID_SIDE) + AW'(c);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/grid_segregation_relocate_step_unit.sv -----
// Top level: segregation grid with write, read and relocate step items.
//
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_stall   | op, row, col, value, target_row, target_col
//  out     | output    | out_valid / out_stall | cell_value, same_count, moved
//  cfg     | input     | cfg_valid / cfg_ready | threshold (saturated to -1..8)
//
// One item at a time over a single-port grid RAM with registered read.
// Steps from accept to result load: a write writes the cell, a read or border relocate
// reads it, an interior relocate reads nine neighbors and, when it moves, the target, then writes two cells.
// A new word is taken once back in idle, while the previous result may still wait.
// Reset is synchronous, active low; grid contents are not cleared.
`default_nettype none
`include "grid_segregation_relocate_step_unit_macros.svh"
module grid_segregation_relocate_step_unit import gsr_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_op,
  input  wire logic [CW-1:0]           in_row,
  input  wire logic [CW-1:0]           in_col,
  input  wire logic                    in_value,
  input  wire logic [CW-1:0]           in_target_row,
  input  wire logic [CW-1:0]           in_target_col,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_cell_value,
  output logic [CNT_W-1:0]             out_same_count,
  output logic                         out_moved,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic signed [THR_W-1:0] cfg_threshold
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = rst_n;

  gsr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  gsr_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_value      (in_value),
    .in_target_row (in_target_row),
    .in_target_col (in_target_col),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_threshold (cfg_threshold),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_cell_value(out_cell_value),
    .out_same_count(out_same_count),
    .out_moved     (out_moved)
  );

  `GSR_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "accept did not start work")
  `GSR_ASSERT(a_write_only_busy, cmd.mem_we |-> in_stall, "grid write while idle")
  `GSR_ASSERT(a_moved_counted, (out_valid && out_moved) |-> (out_same_count <= CNT_W'(8)), "bad count on move")
  `GSR_ASSERT_NR(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule
`default_nettype wire

// ----- rtl/gsr_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module gsr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule
`default_nettype wire

// ----- rtl/gsr_ctrl.sv -----
// Controller: sequences grid memory accesses for one item at a time.
`default_nettype none
module gsr_ctrl import gsr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_WR, S_RD, S_RD_WAIT, S_NB, S_NB_WAIT, S_EVAL,
    S_TGT_RD, S_TGT_WAIT, S_SW_HERE, S_SW_THERE, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  assign in_stall = busy_r || !rst_n;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!sts.in_grid) begin
          state_nxt = S_DONE;
        end else if (sts.op == OP_WRITE) begin
          state_nxt = S_WR;
        end else if (sts.op == OP_RELOCATE && sts.interior) begin
          cmd.nb_clr = 1'b1;
          state_nxt  = S_NB;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        cmd.addr_sel = ADDR_HERE;
        cmd.mem_we   = 1'b1;
        cmd.wd_sel   = WD_VALUE;
        cmd.cell_sel = CELL_VALUE;
        state_nxt    = S_DONE;
      end
      S_RD: begin
        cmd.addr_sel = ADDR_HERE;
        state_nxt    = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        cmd.cell_sel = CELL_RDATA;
        state_nxt    = S_DONE;
      end
      S_NB: begin
        cmd.addr_sel = ADDR_NB;
        cmd.nb_adv   = 1'b1;
        if (sts.nb_last) begin
          state_nxt = S_NB_WAIT;
        end
      end
      S_NB_WAIT: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval     = 1'b1;
        cmd.cell_sel = CELL_CENTRE;
        state_nxt    = sts.moves ? S_TGT_RD : S_DONE;
      end
      S_TGT_RD: begin
        cmd.addr_sel = ADDR_THERE;
        state_nxt    = S_TGT_WAIT;
      end
      S_TGT_WAIT: begin
        cmd.tgt_cap  = 1'b1;
        cmd.cell_sel = CELL_RDATA;
        state_nxt    = S_SW_HERE;
      end
      S_SW_HERE: begin
        cmd.addr_sel = ADDR_HERE;
        cmd.mem_we   = 1'b1;
        cmd.wd_sel   = WD_TVAL;
        state_nxt    = S_SW_THERE;
      end
      S_SW_THERE: begin
        cmd.addr_sel = ADDR_THERE;
        cmd.mem_we   = 1'b1;
        cmd.wd_sel   = WD_CENTRE;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gsr_datapath.sv -----
// Datapath: item registers, neighbor gather and count, threshold, grid RAM, output word.
`default_nettype none
module gsr_datapath import gsr_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  output sts_t                         sts,
  input  wire logic [1:0]              in_op,
  input  wire logic [CW-1:0]           in_row,
  input  wire logic [CW-1:0]           in_col,
  input  wire logic                    in_value,
  input  wire logic [CW-1:0]           in_target_row,
  input  wire logic [CW-1:0]           in_target_col,
  input  wire logic                    cfg_we,
  input  wire logic signed [THR_W-1:0] cfg_threshold,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic                         out_cell_value,
  output logic [CNT_W-1:0]             out_same_count,
  output logic                         out_moved
);

  logic [1:0]              op_r;
  logic [CW-1:0]           row_r, col_r, trow_r, tcol_r;
  logic                    value_r, tval_r, cell_r, moved_r;
  logic [CNT_W-1:0]        count_r;
  logic [NB_CW-1:0]        dr_r, dc_r;
  logic                    cap_vld_r;
  logic [NB_IW-1:0]        cap_idx_r;
  logic [NB_N-1:0]         nb_r;
  logic signed [THR_W-1:0] thr_r, thr_nxt;
  logic                    out_valid_r, out_cell_r, out_moved_r;
  logic [CNT_W-1:0]        out_count_r;

  logic [CW-1:0]    nb_row, nb_col;
  logic [NB_IW-1:0] nb_idx;
  logic             centre;
  logic [NB_N-1:0]  match;
  logic [CNT_W-1:0] cnt_eval;
  logic             moves;
  logic [AW-1:0]    mem_addr;
  logic             mem_wdata, mem_rdata;

  assign nb_row = CW'((CW+1)'(row_r) + (CW+1)'(dr_r) - (CW+1)'(1));
  assign nb_col = CW'((CW+1)'(col_r) + (CW+1)'(dc_r) - (CW+1)'(1));
  assign nb_idx = NB_IW'(NB_IW'(dr_r) * NB_IW'(NB_SIDE) + NB_IW'(dc_r));

  // Centre matches itself, hence the minus one.
  assign centre   = nb_r[CENTRE_IDX];
  assign match    = ~(nb_r ^ {NB_N{centre}});
  assign cnt_eval = CNT_W'($countones(match) - 1);
  assign moves    = $signed({1'b0, cnt_eval}) <= thr_r;

  always_comb begin
    case (cmd.addr_sel)
      ADDR_HERE:  mem_addr = cell_addr(row_r, col_r);
      ADDR_NB:    mem_addr = cell_addr(nb_row, nb_col);
      ADDR_THERE: mem_addr = cell_addr(trow_r, tcol_r);
      default:    mem_addr = cell_addr(row_r, col_r);
    endcase
    case (cmd.wd_sel)
      WD_VALUE:  mem_wdata = value_r;
      WD_TVAL:   mem_wdata = tval_r;
      WD_CENTRE: mem_wdata = centre;
      default:   mem_wdata = value_r;
    endcase
  end

  gsr_ram #(
    .WIDTH(1),
    .DEPTH(GRID_SIDE * GRID_SIDE)
  ) u_grid (
    .clk  (clk),
    .we   (cmd.mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_we) begin
      if (cfg_threshold < THR_MIN) begin
        thr_nxt = THR_MIN;
      end else if (cfg_threshold > THR_MAX) begin
        thr_nxt = THR_MAX;
      end else begin
        thr_nxt = cfg_threshold;
      end
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.in_grid  = ({1'b0, row_r} < (CW+1)'(GRID_SIDE)) &&
                   ({1'b0, col_r} < (CW+1)'(GRID_SIDE));
    sts.interior = (row_r != '0) && (col_r != '0) &&
                   ((CW+1)'(row_r) + (CW+1)'(1) < (CW+1)'(GRID_SIDE)) &&
                   ((CW+1)'(col_r) + (CW+1)'(1) < (CW+1)'(GRID_SIDE));
    sts.nb_last  = (dr_r == NB_CW'(NB_SIDE - 1)) && (dc_r == NB_CW'(NB_SIDE - 1));
    sts.moves    = moves;
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r    <= in_op;
      row_r   <= in_row;
      col_r   <= in_col;
      value_r <= in_value;
      trow_r  <= CW'(in_target_row % GRID_SIDE);
      tcol_r  <= CW'(in_target_col % GRID_SIDE);
      cell_r  <= 1'b0;
      count_r <= '0;
      moved_r <= 1'b0;
    end else begin
      case (cmd.cell_sel)
        CELL_VALUE:  cell_r <= value_r;
        CELL_RDATA:  cell_r <= mem_rdata;
        CELL_CENTRE: cell_r <= centre;
        default:     cell_r <= cell_r;
      endcase
      if (cmd.eval) begin
        count_r <= cnt_eval;
        moved_r <= moves;
      end
    end
    if (cmd.nb_clr) begin
      dr_r <= '0;
      dc_r <= '0;
    end else if (cmd.nb_adv) begin
      if (dc_r == NB_CW'(NB_SIDE - 1)) begin
        dc_r <= '0;
        dr_r <= dr_r + NB_CW'(1);
      end else begin
        dc_r <= dc_r + NB_CW'(1);
      end
    end
    cap_idx_r <= nb_idx;
    if (cap_vld_r) begin
      nb_r[cap_idx_r] <= mem_rdata;
    end
    if (cmd.tgt_cap) begin
      tval_r <= mem_rdata;
    end
    if (cmd.out_load) begin
      out_cell_r  <= cell_r;
      out_count_r <= count_r;
      out_moved_r <= moved_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r   <= 1'b0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cap_vld_r <= cmd.nb_adv;
      thr_r     <= thr_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_same_count = out_count_r;
  assign out_moved      = out_moved_r;

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the grid relocate step unit: directed table, then random phases.
`timescale 1ns / 100ps
module testbench;
  import gsr_pkg::*;

  localparam logic [1:0] OP_ALIAS_READ = 2'd3;
  localparam int WIN_SIDE = 6;
  localparam int PHASES = 8;
  localparam int MIXED_WORDS = 70;
  localparam int LONG_HOLD = 350;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]    op;
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic          value;
    logic [CW-1:0] trow;
    logic [CW-1:0] tcol;
  } grid_word_t;

  typedef struct packed {
    logic             cell_value;
    logic [CNT_W-1:0] count;
    logic             moved;
  } cell_result_t;

  typedef struct packed {
    grid_word_t   w;
    logic         typed;
    cell_result_t x;
  } step_row_t;

  localparam int DIR_N = 23;
  localparam step_row_t DIRECTED [DIR_N] = '{
    '{'{OP_WRITE, 0, 0, 1, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_WRITE, 0, 1, 1, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_WRITE, 0, 2, 1, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_WRITE, 1, 0, 1, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_WRITE, 1, 1, 1, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_WRITE, 1, 2, 1, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_WRITE, 2, 0, 1, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_WRITE, 2, 1, 1, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_WRITE, 2, 2, 1, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_RELOCATE, 1, 1, 0, 1, 1}, 1, '{1, 8, 0}},
    '{'{OP_WRITE, 1, 1, 0, 0, 0}, 1, '{0, 0, 0}},
    '{'{OP_RELOCATE, 1, 1, 0, 0, 0}, 1, '{1, 0, 1}},
    '{'{OP_READ, 0, 0, 0, 0, 0}, 1, '{0, 0, 0}},
    '{'{OP_READ, 1, 1, 0, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_RELOCATE, 0, 2, 0, 5, 5}, 1, '{1, 0, 0}},
    '{'{OP_WRITE, 63, 63, 1, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_READ, 63, 63, 0, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_RELOCATE, 63, 63, 0, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_ALIAS_READ, 63, 63, 0, 0, 0}, 1, '{1, 0, 0}},
    '{'{OP_WRITE, 1, 1, 0, 0, 0}, 1, '{0, 0, 0}},
    '{'{OP_RELOCATE, 1, 1, 0, 1, 1}, 1, '{0, 1, 1}},
    '{'{OP_RELOCATE, 1, 1, 0, 63, 63}, 0, '{0, 0, 0}},
    '{'{OP_READ, 63, 63, 0, 0, 0}, 1, '{0, 0, 0}}
  };

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_op;
  logic [CW-1:0] in_row, in_col, in_target_row, in_target_col;
  logic in_value;
  logic out_valid, out_stall;
  logic out_cell_value, out_moved;
  logic [CNT_W-1:0] out_same_count;
  logic cfg_valid, cfg_ready;
  logic signed [THR_W-1:0] cfg_threshold;

  grid_segregation_relocate_step_unit dut (.*);

  logic cell_grid [GRID_SIDE*GRID_SIDE];
  bit cell_written [GRID_SIDE*GRID_SIDE];
  int move_threshold;
  cell_result_t expected_results [$];
  int errors, words_sent, results_checked, moves_predicted;
  bit calm;

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp_threshold(logic signed [THR_W-1:0] raw);
    if (raw < THR_MIN) return int'(THR_MIN);
    if (raw > THR_MAX) return int'(THR_MAX);
    return int'(raw);
  endfunction

  function automatic bit relocate_safe(int r, int c);
    int dr, dc;
    if (r == 0 || c == 0 || r == GRID_SIDE - 1 || c == GRID_SIDE - 1)
      return cell_written[r*GRID_SIDE + c];
    for (dr = -1; dr <= 1; dr++)
      for (dc = -1; dc <= 1; dc++)
        if (!cell_written[(r + dr)*GRID_SIDE + c + dc]) return 0;
    return 1;
  endfunction

  task automatic predict_cell_step(input grid_word_t w, output cell_result_t res);
    int r, c, here, there, n, dr, dc;
    logic centre;
    r = w.row;
    c = w.col;
    res = '0;
    if (r < GRID_SIDE && c < GRID_SIDE) begin
      here = r*GRID_SIDE + c;
      if (w.op == OP_WRITE) begin
        cell_grid[here] = w.value;
        cell_written[here] = 1;
      end else if (w.op == OP_RELOCATE && r >= 1 && c >= 1 &&
                   r + 1 < GRID_SIDE && c + 1 < GRID_SIDE) begin
        centre = cell_grid[here];
        n = 0;
        for (dr = -1; dr <= 1; dr++)
          for (dc = -1; dc <= 1; dc++)
            if ((dr != 0 || dc != 0) && cell_grid[(r + dr)*GRID_SIDE + c + dc] == centre)
              n++;
        res.count = CNT_W'(n);
        if (n <= move_threshold) begin
          there = (w.trow % GRID_SIDE)*GRID_SIDE + (w.tcol % GRID_SIDE);
          cell_grid[here] = cell_grid[there];
          cell_grid[there] = centre;
          res.moved = 1;
          moves_predicted++;
        end
      end
      res.cell_value = cell_grid[here];
    end
  endtask

  task automatic send_word(input grid_word_t w, input logic typed, input cell_result_t xres);
    int gap;
    cell_result_t res;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= w.op;
    in_row <= w.row;
    in_col <= w.col;
    in_value <= w.value;
    in_target_row <= w.trow;
    in_target_col <= w.tcol;
    do @(posedge clk); while (in_stall);
    predict_cell_step(w, res);
    expected_results.push_back(typed ? xres : res);
    words_sent++;
  endtask

  task automatic write_threshold(input logic signed [THR_W-1:0] raw);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_threshold <= raw;
    do @(posedge clk); while (!cfg_ready);
    move_threshold = clamp_threshold(raw);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // fill a 6x6 window with random types, then mix reads, writes and relocates, mostly inside it
  task automatic run_phase(input int r0, input int c0, input int density);
    int r, c, k, p;
    grid_word_t w;
    for (r = r0; r < r0 + WIN_SIDE; r++)
      for (c = c0; c < c0 + WIN_SIDE; c++) begin
        w = '{OP_WRITE, CW'(r), CW'(c), $urandom_range(0, 99) < density,
              CW'($urandom_range(0, 63)), CW'($urandom_range(0, 63))};
        send_word(w, 0, '0);
      end
    for (k = 0; k < MIXED_WORDS; k++) begin
      p = $urandom_range(0, 99);
      w.row = CW'(r0 + $urandom_range(0, WIN_SIDE - 1));
      w.col = CW'(c0 + $urandom_range(0, WIN_SIDE - 1));
      w.value = 1'($urandom_range(0, 1));
      w.trow = CW'($urandom_range(0, 63));
      w.tcol = CW'($urandom_range(0, 63));
      if (p < 5) begin
        w.op = OP_WRITE;
        w.row = CW'($urandom_range(0, 63));
        w.col = CW'($urandom_range(0, 63));
      end else if (p < 20) begin
        w.op = OP_WRITE;
      end else if (p < 35) begin
        w.op = $urandom_range(0, 3) == 0 ? OP_ALIAS_READ : OP_READ;
      end else begin
        w.op = OP_RELOCATE;
        if (!relocate_safe(w.row, w.col)) begin
          w.row = CW'(r0 + $urandom_range(1, WIN_SIDE - 2));
          w.col = CW'(c0 + $urandom_range(1, WIN_SIDE - 2));
        end
        w.trow = CW'(r0 + $urandom_range(0, WIN_SIDE - 1));
        w.tcol = CW'(c0 + $urandom_range(0, WIN_SIDE - 1));
        if ($urandom_range(0, 9) == 0) begin
          w.trow = w.row;
          w.tcol = w.col;
        end
      end
      send_word(w, 0, '0);
    end
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t ns: result word with none expected, actual cell %0d count %0d moved %0d",
                 $time, out_cell_value, out_same_count, out_moved);
        errors++;
      end else begin
        want = expected_results.pop_front();
        report_field("cell_value", want.cell_value, out_cell_value);
        report_field("same_count", want.count, out_same_count);
        report_field("moved", want.moved, out_moved);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: timeout, %0d result words outstanding", $time,
               expected_results.size());
      $display("grid_segregation_relocate_step_unit: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin : receiver
    int stall_left;
    bit held;
    stall_left = 0;
    held = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_checked >= 300) begin
        held = 1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    logic signed [THR_W-1:0] thr_list [PHASES];
    int i, ph, r0, c0;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_READ;
    in_row = '0;
    in_col = '0;
    in_value = 1'b0;
    in_target_row = '0;
    in_target_col = '0;
    cfg_valid = 1'b0;
    cfg_threshold = THR_RESET;
    calm = 0;
    errors = 0;
    words_sent = 0;
    results_checked = 0;
    moves_predicted = 0;
    move_threshold = clamp_threshold(THR_RESET);
    thr_list = '{5'sd15, -5'sd16, 5'sd2, -5'sd1, 5'sd8, 5'sd4, 5'sd0, 5'sd3};
    thr_list[6] = THR_W'($urandom_range(0, 31));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_N; i++)
      send_word(DIRECTED[i].w, DIRECTED[i].typed, DIRECTED[i].x);
    @(negedge clk);
    in_valid <= 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drain();
      write_threshold(thr_list[ph]);
      calm = (ph == 2 || ph == 5);
      case (ph)
        0: begin r0 = 0; c0 = 0; end
        1: begin r0 = GRID_SIDE - WIN_SIDE; c0 = GRID_SIDE - WIN_SIDE; end
        2: begin r0 = 0; c0 = GRID_SIDE - WIN_SIDE; end
        3: begin r0 = GRID_SIDE - WIN_SIDE; c0 = 0; end
        default: begin
          r0 = $urandom_range(0, GRID_SIDE - WIN_SIDE);
          c0 = $urandom_range(0, GRID_SIDE - WIN_SIDE);
        end
      endcase
      run_phase(r0, c0, $urandom_range(5, 95));
      @(negedge clk);
      in_valid <= 1'b0;
    end

    wait_drain();
    calm = 1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words over %0d threshold settings; %0d results checked, %0d moves.",
             words_sent, PHASES + 1, results_checked, moves_predicted);
    if (errors == 0) begin
      $display("grid_segregation_relocate_step_unit: match");
    end else begin
      $display("%0d field mismatches", errors);
      $display("grid_segregation_relocate_step_unit: mismatch");
    end
    $finish;
  end

endmodule
